>>> src/ccu_pkg.sv
// Calendar clock unit package: field widths, range limits, request and time types.
// Depends on nothing; used by every module of the calendar clock unit.
`timescale 1ns / 1ps

package ccu_pkg;

   // Milliseconds per second; the millisecond counter wraps at this count.
   localparam int MS_PER_SECOND = 1000;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int MS_W    = 10;
   localparam int YMOD_W  = 9;    // year modulo 400

   localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
   localparam logic [MONTH_W-1:0] MONTH_MIN  = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_MAX  = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   DAY_MIN    = DAY_W'(1);
   localparam logic [HOUR_W-1:0]  HOUR_MAX   = HOUR_W'(23);
   localparam logic [MIN_W-1:0]   MINUTE_MAX = MIN_W'(59);
   localparam logic [SEC_W-1:0]   SECOND_MAX = SEC_W'(59);
   localparam logic [MS_W-1:0]    MS_LAST    = MS_W'(MS_PER_SECOND - 1);
   localparam logic [YMOD_W-1:0]  YMOD_LAST  = YMOD_W'(399);

   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              command;
      logic [YEAR_W-1:0]    set_year;
      logic [MONTH_W-1:0]   set_month;
      logic [DAY_W-1:0]     set_day;
      logic [HOUR_W-1:0]    set_hour;
      logic [MIN_W-1:0]     set_minute;
      logic [SEC_W-1:0]     set_second;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [YMOD_W-1:0]    ymod;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [HOUR_W-1:0]    hour;
      logic [MIN_W-1:0]     minute;
      logic [SEC_W-1:0]     second;
      logic [MS_W-1:0]      msec;
   } time_type;

endpackage

>>> src/calendar_clock_unit.sv
// Calendar clock unit: millisecond-tick date and time, Gregorian leap years save year 0.
// A request passes the request register, then the time register, before its result is valid.
// Throughput: one request per cycle unless rsp_ready stalls, set by single-pass time update.
// Reset: time goes to year 0, January 1, 00:00:00.000; request and result stages empty.
// Depends on ccu_pkg, ccu_load and ccu_advance.
`timescale 1ns / 1ps

module calendar_clock_unit (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [ccu_pkg::YEAR_W-1:0]    req_set_year,
   input  logic [ccu_pkg::MONTH_W-1:0]   req_set_month,
   input  logic [ccu_pkg::DAY_W-1:0]     req_set_day,
   input  logic [ccu_pkg::HOUR_W-1:0]    req_set_hour,
   input  logic [ccu_pkg::MIN_W-1:0]     req_set_minute,
   input  logic [ccu_pkg::SEC_W-1:0]     req_set_second,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ccu_pkg::YEAR_W-1:0]    rsp_year,
   output logic [ccu_pkg::MONTH_W-1:0]   rsp_month,
   output logic [ccu_pkg::DAY_W-1:0]     rsp_day,
   output logic [ccu_pkg::HOUR_W-1:0]    rsp_hour,
   output logic [ccu_pkg::MIN_W-1:0]     rsp_minute,
   output logic [ccu_pkg::SEC_W-1:0]     rsp_second,
   output logic [ccu_pkg::MS_W-1:0]      rsp_msec
);

   // Request stage: holds one accepted request until the time register takes it.
   logic                 s1_vld_ff;
   ccu_pkg::req_type     s1_req_ff;
   ccu_pkg::req_type     req_in;

   // Time register: the running clock state, which is also the result payload.
   ccu_pkg::time_type    time_ff;
   ccu_pkg::time_type    time_in;
   logic                 rsp_valid_ff;

   ccu_pkg::time_type    loaded;
   ccu_pkg::time_type    advanced;

   logic                 req_fire;
   logic                 out_free;
   logic                 s1_move;

   // The result slot frees when it is empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_vld_ff && out_free;
   // Take a new request whenever the request stage is empty or moving on.
   assign req_ready = !s1_vld_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      req_in.command    = ccu_pkg::cmd_type'(req_command);
      req_in.set_year   = req_set_year;
      req_in.set_month  = req_set_month;
      req_in.set_day    = req_set_day;
      req_in.set_hour   = req_set_hour;
      req_in.set_minute = req_set_minute;
      req_in.set_second = req_set_second;
   end

   ccu_load u_load (
      .req      (s1_req_ff),
      .cur_msec (time_ff.msec),
      .loaded   (loaded)
   );

   ccu_advance u_advance (
      .cur (time_ff),
      .nxt (advanced)
   );

   // Select the new time: a load replaces the date and time, a tick advances it.
   always_comb begin
      unique case (s1_req_ff.command)
         ccu_pkg::CMD_LOAD: time_in = loaded;
         ccu_pkg::CMD_TICK: time_in = advanced;
         default:           time_in = advanced;
      endcase
   end

   // Capture requests; payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_fire) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_move) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // Advance the clock state and present it as the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.year   <= '0;
         time_ff.ymod   <= '0;
         time_ff.month  <= ccu_pkg::MONTH_MIN;
         time_ff.day    <= ccu_pkg::DAY_MIN;
         time_ff.hour   <= '0;
         time_ff.minute <= '0;
         time_ff.second <= '0;
         time_ff.msec   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (s1_move) begin
            time_ff      <= time_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = time_ff.year;
   assign rsp_month  = time_ff.month;
   assign rsp_day    = time_ff.day;
   assign rsp_hour   = time_ff.hour;
   assign rsp_minute = time_ff.minute;
   assign rsp_second = time_ff.second;
   assign rsp_msec   = time_ff.msec;

   // A request waiting in the request stage reaches the result slot once it frees.
   a_move_to_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && out_free |=> rsp_valid_ff)
      else $error("request stage did not deliver into a free result slot");

   // An accepted request always occupies the request stage next cycle.
   a_accept_held : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_vld_ff)
      else $error("accepted request was lost");

   // The time state stays within its counting ranges.
   a_time_range : assert property (@(posedge clock) disable iff (reset)
      (time_ff.msec <= ccu_pkg::MS_LAST) && (time_ff.ymod <= ccu_pkg::YMOD_LAST)
      && (time_ff.month >= ccu_pkg::MONTH_MIN) && (time_ff.month <= ccu_pkg::MONTH_MAX))
      else $error("time state out of range");

   // The time only changes when a request moves into the result slot.
   a_time_quiet : assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(time_ff))
      else $error("time changed without a request");

   // Reset empties both stages.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_vld_ff)
      else $error("stages not empty after reset");

endmodule

>>> src/ccu_load.sv
// Load path: saturates the request (day at low bound only) and derives year mod 400.
// Depends on ccu_pkg.
`timescale 1ns / 1ps

module ccu_load (
   input  ccu_pkg::req_type              req,
   input  logic [ccu_pkg::MS_W-1:0]      cur_msec,
   output ccu_pkg::time_type             loaded
);

   // floor(y / 400) = (y * 41944) >> 24, exact for y up to 9999
   localparam int RECIP_W = 16;
   localparam int SHIFT   = 24;
   localparam int PROD_W  = ccu_pkg::YEAR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'(41944);

   logic [ccu_pkg::YEAR_W-1:0] year_sat;
   logic [PROD_W-1:0]          prod;
   logic [PROD_W-SHIFT-1:0]    quot;
   logic [ccu_pkg::YEAR_W-1:0] quot_x400;
   logic [ccu_pkg::YEAR_W-1:0] rem;

   always_comb begin
      year_sat  = (req.set_year > ccu_pkg::YEAR_MAX) ? ccu_pkg::YEAR_MAX : req.set_year;
      prod      = PROD_W'(year_sat) * PROD_W'(RECIP_400);
      quot      = prod[PROD_W-1:SHIFT];
      // 400 = 256 + 128 + 16
      quot_x400 = (ccu_pkg::YEAR_W'(quot) << 8) + (ccu_pkg::YEAR_W'(quot) << 7)
                + (ccu_pkg::YEAR_W'(quot) << 4);
      rem       = year_sat - quot_x400;
   end

   always_comb begin
      loaded.year   = year_sat;
      loaded.ymod   = rem[ccu_pkg::YMOD_W-1:0];
      loaded.month  = (req.set_month < ccu_pkg::MONTH_MIN) ? ccu_pkg::MONTH_MIN :
                      (req.set_month > ccu_pkg::MONTH_MAX) ? ccu_pkg::MONTH_MAX :
                      req.set_month;
      loaded.day    = (req.set_day < ccu_pkg::DAY_MIN) ? ccu_pkg::DAY_MIN : req.set_day;
      loaded.hour   = (req.set_hour > ccu_pkg::HOUR_MAX) ? ccu_pkg::HOUR_MAX : req.set_hour;
      loaded.minute = (req.set_minute > ccu_pkg::MINUTE_MAX) ? ccu_pkg::MINUTE_MAX
                                                             : req.set_minute;
      loaded.second = (req.set_second > ccu_pkg::SECOND_MAX) ? ccu_pkg::SECOND_MAX
                                                             : req.set_second;
      loaded.msec   = cur_msec;
   end

endmodule

>>> src/ccu_advance.sv
// Tick path: advances the time by one millisecond with carries up through the year.
// Depends on ccu_pkg.
`timescale 1ns / 1ps

module ccu_advance (
   input  ccu_pkg::time_type cur,
   output ccu_pkg::time_type nxt
);

   localparam logic [ccu_pkg::YMOD_W-1:0] YMOD_100 = ccu_pkg::YMOD_W'(100);
   localparam logic [ccu_pkg::YMOD_W-1:0] YMOD_200 = ccu_pkg::YMOD_W'(200);
   localparam logic [ccu_pkg::YMOD_W-1:0] YMOD_300 = ccu_pkg::YMOD_W'(300);

   logic                        leap;
   logic                        century;
   logic [ccu_pkg::DAY_W-1:0]   month_len;
   logic                        ms_wrap, sec_wrap, min_wrap, hour_wrap;
   logic                        day_wrap, month_wrap, year_wrap;
   logic                        c_sec, c_min, c_hour, c_day, c_month, c_year;

   always_comb begin
      // a century is leap only when divisible by 400; year 0 is never leap
      century = (cur.ymod == YMOD_100) || (cur.ymod == YMOD_200) || (cur.ymod == YMOD_300);
      leap    = (cur.year != '0) && (cur.ymod[1:0] == 2'b00) && !century;

      unique case (cur.month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd2:                                       month_len = leap ? 5'd29 : 5'd28;
         default:                                    month_len = 5'd30;
      endcase
   end

   always_comb begin
      ms_wrap    = cur.msec   >= ccu_pkg::MS_LAST;
      sec_wrap   = cur.second >= ccu_pkg::SECOND_MAX;
      min_wrap   = cur.minute >= ccu_pkg::MINUTE_MAX;
      hour_wrap  = cur.hour   >= ccu_pkg::HOUR_MAX;
      day_wrap   = cur.day    >= month_len;
      month_wrap = cur.month  >= ccu_pkg::MONTH_MAX;
      year_wrap  = cur.year   >= ccu_pkg::YEAR_MAX;

      c_sec   = ms_wrap;
      c_min   = c_sec   && sec_wrap;
      c_hour  = c_min   && min_wrap;
      c_day   = c_hour  && hour_wrap;
      c_month = c_day   && day_wrap;
      c_year  = c_month && month_wrap;
   end

   always_comb begin
      nxt      = cur;
      nxt.msec = ms_wrap ? '0 : cur.msec + ccu_pkg::MS_W'(1);
      if (c_sec) begin
         nxt.second = sec_wrap ? '0 : cur.second + ccu_pkg::SEC_W'(1);
      end
      if (c_min) begin
         nxt.minute = min_wrap ? '0 : cur.minute + ccu_pkg::MIN_W'(1);
      end
      if (c_hour) begin
         nxt.hour = hour_wrap ? '0 : cur.hour + ccu_pkg::HOUR_W'(1);
      end
      if (c_day) begin
         nxt.day = day_wrap ? ccu_pkg::DAY_MIN : cur.day + ccu_pkg::DAY_W'(1);
      end
      if (c_month) begin
         nxt.month = month_wrap ? ccu_pkg::MONTH_MIN : cur.month + ccu_pkg::MONTH_W'(1);
      end
      if (c_year) begin
         // 9999 mod 400 is 399, so both wrap together
         nxt.year = year_wrap ? '0 : cur.year + ccu_pkg::YEAR_W'(1);
         nxt.ymod = (cur.ymod >= ccu_pkg::YMOD_LAST) ? '0 : cur.ymod + ccu_pkg::YMOD_W'(1);
      end
   end

endmodule
